// ----- rtl/rvf_pkg.sv -----
// ----------------------------------------------------------------------------
// rvf_pkg: shared types and constants of the V-chip rating filter
// Holds the records that travel between the front end, the back end and the
// queues, and the field codes of the program rating packet.
// ----------------------------------------------------------------------------
package rvf_pkg;

    // Depth of each internal queue; two entries sustain one request per cycle while the result side does not stall.
    localparam int RVF_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MPAA_BLOCK = 2'd0;
    localparam logic [1:0] CFG_TV_BLOCK   = 2'd1;
    localparam logic [1:0] CFG_TV_VS      = 2'd2;
    localparam logic [1:0] CFG_TV_LD      = 2'd3;

    // Checksum bias: the two control bytes of the rating packet (1 and 5).
    localparam logic [6:0] CHK_BIAS = 7'd6;

    // Bit of the first byte that marks a rating pair.
    localparam int RATING_BIT = 6;

    // Rating system, bits 4:3 of the first byte.
    localparam logic [1:0] CAT_MPAA_A = 2'd0;
    localparam logic [1:0] CAT_TV     = 2'd1;
    localparam logic [1:0] CAT_MPAA_B = 2'd2;

    // TV parental guideline codes, bits 2:0 of the second byte.
    localparam logic [2:0] TV_Y  = 3'd1;
    localparam logic [2:0] TV_Y7 = 3'd2;
    localparam logic [2:0] TV_G  = 3'd3;
    localparam logic [2:0] TV_PG = 3'd4;
    localparam logic [2:0] TV_14 = 3'd5;
    localparam logic [2:0] TV_MA = 3'd6;

    // Content flag positions.
    localparam int FLAG_FV = 0;
    localparam int FLAG_V  = 1;
    localparam int FLAG_S  = 2;
    localparam int FLAG_L  = 3;
    localparam int FLAG_D  = 4;

    typedef struct packed {
        logic [7:0] mpaa_block;
        logic [7:0] tv_block;
        logic [7:0] tv_vs;
        logic [7:0] tv_ld;
    } t_masks;

    // Classified poll, handed from the front end to the back end.
    typedef struct packed {
        logic       checksum_ok;
        logic [6:0] rating_a;
        logic [6:0] rating_b;
        logic [7:0] idle_polls;
    } t_front_rec;

    typedef struct packed {
        logic       checksum_ok;
        logic       block_now;
        logic       release_now;
        logic [2:0] mpaa_rating;
        logic [2:0] tv_rating;
        logic [4:0] content_flags;
        logic [7:0] no_data_count;
    } t_result;

endpackage

// ----- rtl/rvf_queue.sv -----
// ----------------------------------------------------------------------------
// rvf_queue: small first-word-fall-through queue
// Register-based queue with full and empty flags; the head entry is visible
// on the output while the queue is not empty.
// ----------------------------------------------------------------------------
module rvf_queue
    import rvf_pkg::*;
#(
    parameter int  DEPTH = RVF_QUEUE_DEPTH,
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/rvf_front.sv -----
// ----------------------------------------------------------------------------
// rvf_front: poll intake and classification
// Keeps the stored rating pair and the no-data counter, checks the checksum
// pair and hands one classified record per request to the back end.
// ----------------------------------------------------------------------------
module rvf_front
    import rvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_avail,
    input  logic       i_two_bytes,
    input  logic [7:0] i_first_hi,
    input  logic [7:0] i_first_lo,
    input  logic       i_second_present,
    input  logic [7:0] i_second_hi,
    input  logic [7:0] i_second_lo,
    input  logic       i_rec_full,
    output logic       o_rec_push,
    output t_front_rec o_rec
);

    logic [6:0] r_rating_a, n_rating_a;
    logic [6:0] r_rating_b, n_rating_b;
    logic [7:0] r_idle_polls, n_idle_polls;
    logic [6:0] chk_sum;
    logic       accept;
    logic       pair_in;

    assign o_full     = i_rec_full;
    assign accept     = i_push && !i_rec_full;
    assign o_rec_push = accept;
    assign pair_in    = i_avail && i_two_bytes;

    always_comb begin
        n_rating_a   = r_rating_a;
        n_rating_b   = r_rating_b;
        n_idle_polls = r_idle_polls;
        if (!i_avail) begin
            n_idle_polls = r_idle_polls + 1'b1;
        end else if (i_two_bytes) begin
            n_idle_polls = '0;
            if (i_first_hi[RATING_BIT]) begin
                n_rating_a = i_first_hi[6:0];
                n_rating_b = i_first_lo[6:0];
            end
        end
    end

    // The checksum covers the pair as stored after this request.
    assign chk_sum = CHK_BIAS + n_rating_a + n_rating_b + i_second_hi[6:0]
                   + i_second_lo[6:0];

    always_comb begin
        o_rec.checksum_ok = pair_in && i_second_present && (chk_sum == '0);
        o_rec.rating_a    = n_rating_a;
        o_rec.rating_b    = n_rating_b;
        o_rec.idle_polls  = n_idle_polls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rating_a   <= '0;
            r_rating_b   <= '0;
            r_idle_polls <= '0;
        end else if (accept) begin
            r_rating_a   <= n_rating_a;
            r_rating_b   <= n_rating_b;
            r_idle_polls <= n_idle_polls;
        end
    end

endmodule

// ----- rtl/rvf_back.sv -----
// ----------------------------------------------------------------------------
// rvf_back: block decision and rating record
// Tests a checksum-good rating pair against the block masks, keeps the
// sticky rating and content flags and forms the result.
// ----------------------------------------------------------------------------
module rvf_back
    import rvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_masks     i_masks,
    input  logic       i_rec_valid,
    input  t_front_rec i_rec,
    output logic       o_rec_pop,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);

    logic [2:0] r_seen_mpaa, n_seen_mpaa;
    logic [2:0] r_seen_tv, n_seen_tv;
    logic [4:0] r_seen_flags, n_seen_flags;
    logic [6:0] a;
    logic [6:0] b;
    logic [1:0] cat;
    logic [2:0] mpaa_code;
    logic [2:0] tv_code;
    logic       is_rating;
    logic       is_mpaa;
    logic       is_tv;
    logic       f_v, f_s, f_l, f_d;
    logic       tv_block;
    logic       must_block;
    logic       blk;
    logic       step;
    logic [4:0] new_flags;

    assign step       = i_rec_valid && !i_res_full;
    assign o_rec_pop  = step;
    assign o_res_push = step;

    assign a         = i_rec.rating_a;
    assign b         = i_rec.rating_b;
    assign cat       = a[4:3];
    assign mpaa_code = a[2:0];
    assign tv_code   = b[2:0];
    assign is_rating = a[RATING_BIT];
    assign is_mpaa   = is_rating && (cat == CAT_MPAA_A || cat == CAT_MPAA_B);
    assign is_tv     = is_rating && (cat == CAT_TV);
    assign f_v       = b[5];
    assign f_s       = b[4];
    assign f_l       = b[3];
    assign f_d       = a[5];

    always_comb begin
        case (tv_code)
            TV_Y:    tv_block = i_masks.tv_block[0];
            TV_Y7:   tv_block = i_masks.tv_block[1] || (f_v && i_masks.tv_block[2]);
            TV_G:    tv_block = i_masks.tv_block[4];
            TV_PG:   tv_block = i_masks.tv_block[5] || (f_v && i_masks.tv_vs[0])
                              || (f_s && i_masks.tv_vs[4]) || (f_l && i_masks.tv_ld[0])
                              || (f_d && i_masks.tv_ld[4]);
            TV_14:   tv_block = i_masks.tv_block[6] || (f_v && i_masks.tv_vs[1])
                              || (f_s && i_masks.tv_vs[5]) || (f_l && i_masks.tv_ld[1])
                              || (f_d && i_masks.tv_ld[5]);
            TV_MA:   tv_block = i_masks.tv_block[7] || (f_v && i_masks.tv_vs[2])
                              || (f_s && i_masks.tv_vs[6]) || (f_l && i_masks.tv_ld[2]);
            default: tv_block = 1'b0;
        endcase
    end

    always_comb begin
        must_block = 1'b0;
        if (is_mpaa) begin
            must_block = (mpaa_code != 3'd0)
                       && i_masks.mpaa_block[3'(mpaa_code - 3'd1)];
        end else if (is_tv) begin
            must_block = tv_block;
        end
    end

    assign blk = i_rec.checksum_ok && must_block;

    // A block implies a nonzero MPAA code or a TV code from TV-Y to TV-MA.
    always_comb begin
        new_flags          = '0;
        new_flags[FLAG_FV] = (tv_code == TV_Y7) && f_v;
        if (tv_code == TV_PG || tv_code == TV_14 || tv_code == TV_MA) begin
            new_flags[FLAG_V] = f_v;
            new_flags[FLAG_S] = f_s;
            new_flags[FLAG_L] = f_l;
            new_flags[FLAG_D] = (tv_code != TV_MA) && f_d;
        end
    end

    always_comb begin
        n_seen_mpaa  = r_seen_mpaa;
        n_seen_tv    = r_seen_tv;
        n_seen_flags = r_seen_flags;
        if (blk) begin
            if (is_mpaa) begin
                n_seen_mpaa = mpaa_code;
            end else begin
                n_seen_tv    = tv_code;
                n_seen_flags = r_seen_flags | new_flags;
            end
        end
    end

    always_comb begin
        o_res.checksum_ok   = i_rec.checksum_ok;
        o_res.block_now     = blk;
        o_res.release_now   = i_rec.checksum_ok && !must_block;
        o_res.mpaa_rating   = n_seen_mpaa;
        o_res.tv_rating     = n_seen_tv;
        o_res.content_flags = n_seen_flags;
        o_res.no_data_count = i_rec.idle_polls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_mpaa  <= '0;
            r_seen_tv    <= '0;
            r_seen_flags <= '0;
        end else if (step) begin
            r_seen_mpaa  <= n_seen_mpaa;
            r_seen_tv    <= n_seen_tv;
            r_seen_flags <= n_seen_flags;
        end
    end

endmodule

// ----- rtl/vchip_rating_filter_core.sv -----
// ----------------------------------------------------------------------------
// vchip_rating_filter_core: V-chip content advisory filter
// Takes caption decoder poll results, checks the program rating packet and
// reports block or release decisions with the sticky rating state.
// ----------------------------------------------------------------------------
// Each request is one poll of the caption decoder and yields exactly one
// result, in order. The block takes a request in every cycle while full is
// low. In the cycle of the request the front end, which keeps the rating
// pair and the no-data counter and checks the checksum, writes its record
// into the middle queue. Once that record heads the middle queue and the
// result queue is not full, the back end makes the block decision on that
// record and writes the result queue, whose head drives the result ports
// from the cycle after. Two queues of QUEUE_DEPTH entries each, one between
// front and back end and one at the output, absorb stalls on the result
// side, so full rises only once both are filled. The user must write the four
// mask registers through the configuration port only while no request is in
// flight; the block itself does not enforce this. They take effect at the next request.
// ----------------------------------------------------------------------------
module vchip_rating_filter_core
    import rvf_pkg::*;
#(
    parameter int QUEUE_DEPTH = RVF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration writes.
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    // Request side.
    input  logic       push,
    output logic       full,
    input  logic       i_avail,
    input  logic       i_two_bytes,
    input  logic [7:0] i_first_hi,
    input  logic [7:0] i_first_lo,
    input  logic       i_second_present,
    input  logic [7:0] i_second_hi,
    input  logic [7:0] i_second_lo,
    // Result side.
    output logic       empty,
    input  logic       pop,
    output logic       o_checksum_ok,
    output logic       o_block_now,
    output logic       o_release_now,
    output logic [2:0] o_mpaa_rating,
    output logic [2:0] o_tv_rating,
    output logic [4:0] o_content_flags,
    output logic [7:0] o_no_data_count
);

    t_masks     r_masks;
    t_front_rec front_rec;
    t_front_rec mid_rec;
    t_result    back_res;
    t_result    out_res;
    logic       front_push;
    logic       mid_full;
    logic       mid_empty;
    logic       mid_pop;
    logic       res_push;
    logic       res_full;

    // Block mask registers; all clear at reset, so nothing is blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MPAA_BLOCK: r_masks.mpaa_block <= i_cfg_wdata;
                CFG_TV_BLOCK:   r_masks.tv_block   <= i_cfg_wdata;
                CFG_TV_VS:      r_masks.tv_vs      <= i_cfg_wdata;
                CFG_TV_LD:      r_masks.tv_ld      <= i_cfg_wdata;
                default:        r_masks            <= r_masks;
            endcase
        end
    end

    // Front end: request intake, rating pair storage and checksum check.
    rvf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_avail          (i_avail),
        .i_two_bytes      (i_two_bytes),
        .i_first_hi       (i_first_hi),
        .i_first_lo       (i_first_lo),
        .i_second_present (i_second_present),
        .i_second_hi      (i_second_hi),
        .i_second_lo      (i_second_lo),
        .i_rec_full       (mid_full),
        .o_rec_push       (front_push),
        .o_rec            (front_rec)
    );

    // Queue between the front end and the back end.
    rvf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .t_item (t_front_rec)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_rec),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_item  (mid_rec),
        .o_empty (mid_empty)
    );

    // Back end: block decision and sticky rating record.
    rvf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_masks     (r_masks),
        .i_rec_valid (!mid_empty),
        .i_rec       (mid_rec),
        .o_rec_pop   (mid_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Result queue; its head drives the result ports.
    rvf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .t_item (t_result)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_item  (out_res),
        .o_empty (empty)
    );

    assign o_checksum_ok   = out_res.checksum_ok;
    assign o_block_now     = out_res.block_now;
    assign o_release_now   = out_res.release_now;
    assign o_mpaa_rating   = out_res.mpaa_rating;
    assign o_tv_rating     = out_res.tv_rating;
    assign o_content_flags = out_res.content_flags;
    assign o_no_data_count = out_res.no_data_count;

endmodule
